// File: design/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int HUE_INT_BITS = 9;
  localparam int DEG_FULL     = 360;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } hsv_sector_e;

  typedef struct packed {
    logic valid;
    logic grey;
  } hsv_ctrl_t;

endpackage

// File: design/hsv_prep.sv
// ----------------------------------------------------------------------------
// hsv_prep
// two front stages: max, min, sector and difference, then the dividends
// ----------------------------------------------------------------------------
module hsv_prep #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6,
  parameter int WORK_BITS     = 23
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic [CHANNEL_BITS-1:0]  red_i,
  input  logic [CHANNEL_BITS-1:0]  green_i,
  input  logic [CHANNEL_BITS-1:0]  blue_i,
  output hsv_pkg::hsv_ctrl_t       ctrl_o,
  output logic [CHANNEL_BITS-1:0]  bright_o,
  output logic [CHANNEL_BITS-1:0]  delta_o,
  output logic [WORK_BITS-1:0]     sat_num_o,
  output logic [WORK_BITS-1:0]     hue_num_o
);
  import hsv_pkg::*;

  localparam int C  = CHANNEL_BITS;
  localparam int TW = C + 4;

  // stage a
  logic [C-1:0]        mx, mn;
  logic signed [C:0]   diff;
  hsv_sector_e         sector;

  hsv_ctrl_t           a_ctrl_q, a_ctrl_d;
  logic [C-1:0]        a_mx_q, a_delta_q;
  logic signed [C:0]   a_diff_q;
  hsv_sector_e         a_sector_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
  end

  always_comb begin
    priority if (red_i >= mx) begin
      sector = SECTOR_RED;
      diff   = signed'({1'b0, green_i}) - signed'({1'b0, blue_i});
    end else if (green_i >= mx) begin
      sector = SECTOR_GREEN;
      diff   = signed'({1'b0, blue_i}) - signed'({1'b0, red_i});
    end else begin
      sector = SECTOR_BLUE;
      diff   = signed'({1'b0, red_i}) - signed'({1'b0, green_i});
    end
  end

  always_comb begin
    a_ctrl_d.valid = valid_i;
    a_ctrl_d.grey  = (mx == mn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q <= '0;
    end else if (adv_i) begin
      a_ctrl_q <= a_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_mx_q     <= mx;
      a_delta_q  <= mx - mn;
      a_diff_q   <= diff;
      a_sector_q <= sector;
    end
  end

  // stage b
  logic [TW-1:0]        dlt_w, base, t_raw, t_wrap;
  logic [WORK_BITS-1:0] t_w, hue_num_d, sat_num_d;

  assign dlt_w = TW'(a_delta_q);

  always_comb begin
    unique case (a_sector_q)
      SECTOR_RED:   base = '0;
      SECTOR_GREEN: base = dlt_w << 1;
      SECTOR_BLUE:  base = dlt_w << 2;
      default:      base = '0;
    endcase
  end

  // wrap a negative hue by six sectors
  assign t_raw  = base + {{3{a_diff_q[C]}}, a_diff_q};
  assign t_wrap = t_raw[TW-1] ? (t_raw + (dlt_w << 2) + (dlt_w << 1)) : t_raw;
  assign t_w    = WORK_BITS'(t_wrap[C+2:0]);

  // 60 * t in the hue fraction grid
  assign hue_num_d = (t_w << (6 + HUE_FRAC_BITS)) - (t_w << (2 + HUE_FRAC_BITS));
  assign sat_num_d = (WORK_BITS'(a_delta_q) << C) - WORK_BITS'(a_delta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= a_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bright_o  <= a_mx_q;
      delta_o   <= a_delta_q;
      sat_num_o <= sat_num_d;
      hue_num_o <= hue_num_d;
    end
  end

endmodule

// File: design/hsv_div_step.sv
// ----------------------------------------------------------------------------
// hsv_div_step
// one restoring step of the saturation and hue dividers, one quotient bit
// ----------------------------------------------------------------------------
module hsv_div_step #(
  parameter int CHANNEL_BITS = 8,
  parameter int QUOT_BITS    = 15,
  parameter int WORK_BITS    = 23,
  parameter int BIT_IDX      = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  hsv_pkg::hsv_ctrl_t       ctrl_i,
  input  logic [CHANNEL_BITS-1:0]  bright_i,
  input  logic [CHANNEL_BITS-1:0]  delta_i,
  input  logic [WORK_BITS-1:0]     sat_rem_i,
  input  logic [WORK_BITS-1:0]     hue_rem_i,
  input  logic [QUOT_BITS-1:0]     sat_quo_i,
  input  logic [QUOT_BITS-1:0]     hue_quo_i,
  output hsv_pkg::hsv_ctrl_t       ctrl_o,
  output logic [CHANNEL_BITS-1:0]  bright_o,
  output logic [CHANNEL_BITS-1:0]  delta_o,
  output logic [WORK_BITS-1:0]     sat_rem_o,
  output logic [WORK_BITS-1:0]     hue_rem_o,
  output logic [QUOT_BITS-1:0]     sat_quo_o,
  output logic [QUOT_BITS-1:0]     hue_quo_o
);
  import hsv_pkg::*;

  logic [WORK_BITS-1:0] sat_sub, hue_sub;
  logic                 sat_ge, hue_ge;
  logic [WORK_BITS-1:0] sat_rem_d, hue_rem_d;
  logic [QUOT_BITS-1:0] sat_quo_d, hue_quo_d;

  assign sat_sub = WORK_BITS'(bright_i) << BIT_IDX;
  assign hue_sub = WORK_BITS'(delta_i) << BIT_IDX;
  assign sat_ge  = (sat_rem_i >= sat_sub);
  assign hue_ge  = (hue_rem_i >= hue_sub);

  always_comb begin
    sat_rem_d          = sat_ge ? (sat_rem_i - sat_sub) : sat_rem_i;
    hue_rem_d          = hue_ge ? (hue_rem_i - hue_sub) : hue_rem_i;
    sat_quo_d          = sat_quo_i;
    hue_quo_d          = hue_quo_i;
    sat_quo_d[BIT_IDX] = sat_ge;
    hue_quo_d[BIT_IDX] = hue_ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (adv_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bright_o  <= bright_i;
      delta_o   <= delta_i;
      sat_rem_o <= sat_rem_d;
      hue_rem_o <= hue_rem_d;
      sat_quo_o <= sat_quo_d;
      hue_quo_o <= hue_quo_d;
    end
  end

endmodule

// File: design/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// one pixel word comes in on the s_axis channel (red, green, blue) and one
// hsv word leaves on the m_axis channel (hue, saturation, brightness).
// hue is in degrees with HUE_FRAC_BITS fraction bits, below 360; saturation
// is floor(max_code * delta / max); brightness is the largest channel.
// grey and black pixels give zero hue and saturation.
// there are two front stages, then one restoring divider stage per quotient
// bit, QUOT_BITS = max(9 + HUE_FRAC_BITS, CHANNEL_BITS), with saturation and
// hue divided side by side.
// throughput is one pixel per clock; every stage is a register, so a word
// enters on each cycle with s_axis_tready_o high.
// the whole pipeline moves together: when m_axis_tvalid_o is high and
// m_axis_tready_i is low it freezes and s_axis_tready_o drops, nothing
// is lost or repeated; bubbles move on while the output slot is empty.
// reset clears all valid bits; the output is idle after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS  = 8,
  parameter int HUE_FRAC_BITS = 6,
  localparam int HUE_BITS     = 9 + HUE_FRAC_BITS,
  localparam int IN_BITS      = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [IN_BITS-1:0]  s_axis_tdata_i,   // red, green, blue, zero pad
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OUT_BITS-1:0] m_axis_tdata_o    // hue, saturation, brightness, zero pad
);
  import hsv_pkg::*;

  localparam int C          = CHANNEL_BITS;
  localparam int QUOT_BITS  = (HUE_BITS > C) ? HUE_BITS : C;
  localparam int WORK_BITS  = C + QUOT_BITS;

  logic adv;

  hsv_ctrl_t            st_ctrl   [QUOT_BITS+1];
  logic [C-1:0]         st_bright [QUOT_BITS+1];
  logic [C-1:0]         st_delta  [QUOT_BITS+1];
  logic [WORK_BITS-1:0] st_sat_rem[QUOT_BITS+1];
  logic [WORK_BITS-1:0] st_hue_rem[QUOT_BITS+1];
  logic [QUOT_BITS-1:0] st_sat_quo[QUOT_BITS+1];
  logic [QUOT_BITS-1:0] st_hue_quo[QUOT_BITS+1];

  hsv_ctrl_t            last_ctrl;
  logic [HUE_BITS-1:0]  hue;
  logic [C-1:0]         saturation;

  assign last_ctrl       = st_ctrl[QUOT_BITS];
  assign adv             = !last_ctrl.valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  hsv_prep #(
    .CHANNEL_BITS  (C),
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .WORK_BITS     (WORK_BITS)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (s_axis_tvalid_i),
    .red_i     (s_axis_tdata_i[C-1:0]),
    .green_i   (s_axis_tdata_i[2*C-1:C]),
    .blue_i    (s_axis_tdata_i[3*C-1:2*C]),
    .ctrl_o    (st_ctrl[0]),
    .bright_o  (st_bright[0]),
    .delta_o   (st_delta[0]),
    .sat_num_o (st_sat_rem[0]),
    .hue_num_o (st_hue_rem[0])
  );

  assign st_sat_quo[0] = '0;
  assign st_hue_quo[0] = '0;

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    hsv_div_step #(
      .CHANNEL_BITS (C),
      .QUOT_BITS    (QUOT_BITS),
      .WORK_BITS    (WORK_BITS),
      .BIT_IDX      (QUOT_BITS - 1 - k)
    ) u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ctrl_i    (st_ctrl[k]),
      .bright_i  (st_bright[k]),
      .delta_i   (st_delta[k]),
      .sat_rem_i (st_sat_rem[k]),
      .hue_rem_i (st_hue_rem[k]),
      .sat_quo_i (st_sat_quo[k]),
      .hue_quo_i (st_hue_quo[k]),
      .ctrl_o    (st_ctrl[k+1]),
      .bright_o  (st_bright[k+1]),
      .delta_o   (st_delta[k+1]),
      .sat_rem_o (st_sat_rem[k+1]),
      .hue_rem_o (st_hue_rem[k+1]),
      .sat_quo_o (st_sat_quo[k+1]),
      .hue_quo_o (st_hue_quo[k+1])
    );
  end

  assign hue        = last_ctrl.grey ? '0 : st_hue_quo[QUOT_BITS][HUE_BITS-1:0];
  assign saturation = last_ctrl.grey ? '0 : st_sat_quo[QUOT_BITS][C-1:0];

  assign m_axis_tvalid_o = last_ctrl.valid;
  assign m_axis_tdata_o  = OUT_BITS'({st_bright[QUOT_BITS], saturation, hue});

  hue_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_ctrl.valid && !last_ctrl.grey |->
      (WORK_BITS'(st_hue_quo[QUOT_BITS]) < (WORK_BITS'(DEG_FULL) << HUE_FRAC_BITS)))
    else $error("hue quotient beyond a full turn");

  sat_fits_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_ctrl.valid && !last_ctrl.grey |->
      (WORK_BITS'(st_sat_quo[QUOT_BITS]) < (WORK_BITS'(1) << C)))
    else $error("saturation quotient overflows the channel");

  hue_rem_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_ctrl.valid && !last_ctrl.grey |->
      (st_hue_rem[QUOT_BITS] < WORK_BITS'(st_delta[QUOT_BITS])))
    else $error("hue remainder not below delta");

  stall_blocks_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output word stalled");

endmodule

// File: dv/tb_rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// self-checking testbench of the pipelined rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// pixel words go in on the s_axis side and every hsv word that leaves on the
// m_axis side is checked, field by field, against a behavioral model of the
// conversion kept in this file. directed corner pixels come first: black,
// white, greys, pure and mixed primaries, ties between the largest channels
// and negative raw hue. random pixels follow, mostly uniform, with a share of
// greys, ties and near-grey pixels. both sides stall at random, with a stretch
// at full rate and a pause in which the sender waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv_pkg::*;

  localparam int CHAN_BITS    = 8;
  localparam int FRAC_BITS    = 6;
  localparam int HUE_W        = HUE_INT_BITS + FRAC_BITS;
  localparam int CHAN_MAX     = (1 << CHAN_BITS) - 1;
  localparam int PIPE_DEPTH   = 2 + HUE_W;
  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [HUE_W-1:0]     hue;
    logic [CHAN_BITS-1:0] sat;
    logic [CHAN_BITS-1:0] bright;
  } hsv_word_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data  = '0;   // red, green, blue
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;         // hue, saturation, brightness, zero pad

  hsv_word_t hsv_expected[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        idling = 1'b1;

  rgb_to_hsv_converter #(
    .CHANNEL_BITS (CHAN_BITS),
    .HUE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic hsv_word_t hsv_of_pixel(input logic [CHAN_BITS-1:0] r,
                                             input logic [CHAN_BITS-1:0] g,
                                             input logic [CHAN_BITS-1:0] b);
    hsv_word_t            w;
    logic [CHAN_BITS-1:0] hi;
    logic [CHAN_BITS-1:0] lo;
    longint               span;
    longint               diff;
    longint               num;
    hsv_sector_e          sec;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span     = longint'(hi) - longint'(lo);
    w.bright = hi;
    if (span == 0) begin
      w.hue = '0;
      w.sat = '0;
      return w;
    end
    w.sat = CHAN_BITS'((longint'(CHAN_MAX) * span) / longint'(hi));
    if (r == hi) begin
      sec  = SECTOR_RED;
      diff = longint'(g) - longint'(b);
    end else if (g == hi) begin
      sec  = SECTOR_GREEN;
      diff = longint'(b) - longint'(r);
    end else begin
      sec  = SECTOR_BLUE;
      diff = longint'(r) - longint'(g);
    end
    // exact hue times span times 2^frac, wrapped into one turn
    num = (longint'(sec) * 120 * span + 60 * diff) * (longint'(1) << FRAC_BITS);
    if (num < 0) num += longint'(DEG_FULL) * span * (longint'(1) << FRAC_BITS);
    w.hue = HUE_W'(num / span);
    return w;
  endfunction

  // sink side: random stalls, sampled results checked at the rising edge
  always @(negedge clk_i) begin
    m_ready <= idling ? ($urandom_range(99) >= 15) : 1'b1;
  end

  always @(posedge clk_i) begin
    hsv_word_t got;
    hsv_word_t want;
    if (rst_ni && m_valid && m_ready) begin
      got.hue    = m_data[HUE_W-1:0];
      got.sat    = m_data[HUE_W+CHAN_BITS-1:HUE_W];
      got.bright = m_data[HUE_W+2*CHAN_BITS-1:HUE_W+CHAN_BITS];
      if (hsv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected hsv word %h", m_data);
      end else begin
        want = hsv_expected.pop_front();
        if (got.hue != want.hue || got.sat != want.sat || got.bright != want.bright) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("hsv mismatch: hue %0d/%0d sat %0d/%0d bright %0d/%0d (exp/got)",
                     want.hue, got.hue, want.sat, got.sat, want.bright, got.bright);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("** rgb_to_hsv_converter: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (idling && $urandom_range(99) < 15) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {b, g, r};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    hsv_expected.push_back(hsv_of_pixel(r, g, b));
    @(negedge clk_i);
  endtask

  task automatic test_corner_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd85, 8'd170, 8'd170);
    send_pixel(8'd170, 8'd85, 8'd254);
    send_pixel(8'd127, 8'd128, 8'd126);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd2, 8'd3, 8'd255);
  endtask

  task automatic random_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
    logic [7:0] v;
    logic [7:0] w;
    v = 8'($urandom);
    w = 8'($urandom);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(9))
      6: begin
        r = v;
        g = v;
        b = v;
      end
      7: begin
        // two channels tie
        case ($urandom_range(2))
          0: begin r = v; g = v; b = w; end
          1: begin g = v; b = v; r = w; end
          default: begin r = v; b = v; g = w; end
        endcase
      end
      8: begin
        // near grey
        g = 8'(r + $urandom_range(2) - 1);
        b = 8'(r + $urandom_range(2) - 1);
      end
      9: begin
        case ($urandom_range(2))
          0: r = $urandom_range(1) ? 8'd255 : 8'd0;
          1: g = $urandom_range(1) ? 8'd255 : 8'd0;
          default: b = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic test_random_pixels(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    idling = 1'b1;
    repeat (count) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_full_rate(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    idling = 1'b0;
    repeat (count) begin
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
    idling = 1'b1;
  endtask

  task automatic test_drain_pause();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (hsv_expected.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_pixels();
    test_random_pixels(700);
    test_drain_pause();
    test_full_rate(350);
    test_random_pixels(650);
    test_drain_pause();

    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (3 * PIPE_DEPTH) @(posedge clk_i);
    if (mismatches == 0 && hsv_expected.size() == 0) begin
      $display("** rgb_to_hsv_converter: PASSED **");
    end else begin
      $display("** rgb_to_hsv_converter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
design/hsv_pkg.sv
design/hsv_prep.sv
design/hsv_div_step.sv
design/rgb_to_hsv_converter.sv
dv/tb_rgb_to_hsv_converter.sv
